### rtl/srvd_pkg.sv
// Shared types, constants and helpers for the sensor raw value decoder.
`default_nettype none

package srvd_pkg;

    localparam int NUM_PORTS = 4;

    localparam int PORT_W  = 2;
    localparam int RAW_W   = 64;
    localparam int VALUE_W = 17;
    localparam int MODE_W  = 5;
    localparam int CHAN_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_BASE = 3'd4;

    // sensor modes
    localparam logic [MODE_W-1:0] MODE_NONE     = 5'd0;
    localparam logic [MODE_W-1:0] MODE_TOUCH    = 5'd1;
    localparam logic [MODE_W-1:0] MODE_COL_REF  = 5'd2;
    localparam logic [MODE_W-1:0] MODE_COL_AMB  = 5'd3;
    localparam logic [MODE_W-1:0] MODE_COL_COL  = 5'd4;
    localparam logic [MODE_W-1:0] MODE_US_CM    = 5'd5;
    localparam logic [MODE_W-1:0] MODE_US_MM    = 5'd6;
    localparam logic [MODE_W-1:0] MODE_US_IN    = 5'd7;
    localparam logic [MODE_W-1:0] MODE_GY_ANG   = 5'd8;
    localparam logic [MODE_W-1:0] MODE_GY_RATE  = 5'd9;
    localparam logic [MODE_W-1:0] MODE_GY_TILT  = 5'd10;
    localparam logic [MODE_W-1:0] MODE_IR_PROX  = 5'd11;
    localparam logic [MODE_W-1:0] MODE_IR_SEEK  = 5'd12;
    localparam logic [MODE_W-1:0] MODE_IR_REM   = 5'd13;
    localparam logic [MODE_W-1:0] MODE_L_SEEKER = 5'd14;
    localparam logic [MODE_W-1:0] MODE_L_TEMP_C = 5'd15;
    localparam logic [MODE_W-1:0] MODE_L_TEMP_F = 5'd16;
    localparam logic [MODE_W-1:0] MODE_L_US_CM  = 5'd17;
    localparam logic [MODE_W-1:0] MODE_DIR_DC   = 5'd18;
    localparam logic [MODE_W-1:0] MODE_DIR_AC   = 5'd19;
    localparam logic [MODE_W-1:0] MODE_DIR_DALL = 5'd20;
    localparam logic [MODE_W-1:0] MODE_DIR_AALL = 5'd21;
    localparam logic [MODE_W-1:0] MODE_COMPASS  = 5'd22;

    // x/10 for x < 4096 as (x * DIV10_MUL) >> 16
    localparam logic [12:0] DIV10_MUL = 13'd6554;
    // 9t/5 for t <= 1280 as (t * F_MUL) >> 16
    localparam logic [16:0] F_MUL = 17'd117972;
    localparam logic [VALUE_W-1:0] F_OFFSET = 17'd320;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAN_W-1:0] chan;
    } t_port_cfg;

    // n * 10 / 15 for a 4-bit fraction of a degree
    function automatic logic [3:0] frac_tenths(input logic [3:0] n);
        logic [3:0] r;
        unique case (n)
            4'd0:  r = 4'd0;
            4'd1:  r = 4'd0;
            4'd2:  r = 4'd1;
            4'd3:  r = 4'd2;
            4'd4:  r = 4'd2;
            4'd5:  r = 4'd3;
            4'd6:  r = 4'd4;
            4'd7:  r = 4'd4;
            4'd8:  r = 4'd5;
            4'd9:  r = 4'd6;
            4'd10: r = 4'd6;
            4'd11: r = 4'd7;
            4'd12: r = 4'd8;
            4'd13: r = 4'd8;
            4'd14: r = 4'd9;
            default: r = 4'd10;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/sensor_raw_value_decoder.sv
// Throughput: one request per cycle while the output is taken, through the
// four-register decode pipeline (capture, term, select, output). An output
// stall holds only the full stages behind it; empty stages still fill.
// Reset: synchronous, active low; clears all modes to none, beacon channels
// to 0 and empties the pipeline. Configuration writes are taken every cycle.
`default_nettype none

module sensor_raw_value_decoder (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [srvd_pkg::PORT_W-1:0]     i_port,
    input  wire logic [srvd_pkg::RAW_W-1:0]      i_raw_word,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic signed [srvd_pkg::VALUE_W-1:0]  o_value,
    output logic                                 o_no_value,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [srvd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [srvd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import srvd_pkg::*;

    t_port_cfg          port_cfg;
    logic [VALUE_W-1:0] value;

    assign o_cfg_ready = 1'b1;

    srvd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_port      (i_port),
        .o_port_cfg  (port_cfg)
    );

    srvd_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_raw_word  (i_raw_word),
        .i_port_cfg  (port_cfg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (value),
        .o_no_value  (o_no_value)
    );

    assign o_value = $signed(value);

endmodule

`default_nettype wire

### rtl/srvd_cfg.sv
// Per-port mode and beacon channel registers with lookup by port.
`default_nettype none

module srvd_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [srvd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [srvd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [srvd_pkg::PORT_W-1:0]     i_port,
    output srvd_pkg::t_port_cfg                  o_port_cfg
);
    import srvd_pkg::*;

    logic [MODE_W-1:0] r_mode [NUM_PORTS];
    logic [CHAN_W-1:0] r_chan [NUM_PORTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PORTS; p++) begin
                r_mode[p] <= MODE_NONE;
                r_chan[p] <= '0;
            end
        end else if (i_cfg_valid) begin
            for (int p = 0; p < NUM_PORTS; p++) begin
                if (i_cfg_index == REG_MODE_BASE + CFG_IDX_W'(p))
                    r_mode[p] <= i_cfg_data[MODE_W-1:0];
                if (i_cfg_index == REG_CHAN_BASE + CFG_IDX_W'(p))
                    r_chan[p] <= i_cfg_data[CHAN_W-1:0];
            end
        end
    end

    // a port that is not fitted reads as no sensor
    always_comb begin
        if (int'(i_port) < NUM_PORTS) begin
            o_port_cfg.mode = r_mode[i_port];
            o_port_cfg.chan = r_chan[i_port];
        end else begin
            o_port_cfg.mode = MODE_NONE;
            o_port_cfg.chan = '0;
        end
    end

endmodule

`default_nettype wire

### rtl/srvd_pipe.sv
// Four-register decode pipeline: capture, per-mode terms, select, output.
`default_nettype none

module srvd_pipe (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [srvd_pkg::RAW_W-1:0]    i_raw_word,
    input  srvd_pkg::t_port_cfg                i_port_cfg,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [srvd_pkg::VALUE_W-1:0]       o_value,
    output logic                               o_no_value
);
    import srvd_pkg::*;

    logic en_s1, en_s2, en_s3, en_out;

    // stage 1: capture
    logic              r_s1_valid;
    logic [MODE_W-1:0] r_s1_mode;
    logic [15:0]       r_s1_w16;
    logic [7:0]        r_s1_seek;
    logic [7:0]        r_s1_rem;
    logic [7:0]        n_s1_seek;
    logic [7:0]        n_s1_rem;

    // stage 2: per-mode terms
    logic              r_s2_valid;
    logic [MODE_W-1:0] r_s2_mode;
    logic [15:0]       r_s2_w16;
    logic [7:0]        r_s2_seek;
    logic [7:0]        r_s2_rem;
    logic [8:0]        r_s2_div10;
    logic [10:0]       r_s2_temp;
    logic              r_s2_neg;
    logic [24:0]       n_s2_prod;
    logic [11:0]       n_s2_hmag;
    logic [10:0]       n_s2_temp;

    // stage 3: selection
    logic               r_s3_valid;
    logic [VALUE_W-1:0] r_s3_value;
    logic               r_s3_nv;
    logic               r_s3_is_f;
    logic               r_s3_neg;
    logic [11:0]        r_s3_fq;
    logic [VALUE_W-1:0] n_s3_value;
    logic               n_s3_nv;
    logic [27:0]        n_s3_fprod;
    logic [VALUE_W-1:0] n_s3_ctemp;

    // output
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_nv;
    logic [VALUE_W-1:0] n_out_value;
    logic [VALUE_W-1:0] n_out_fsigned;

    assign en_out     = !r_out_valid || i_out_ready;
    assign en_s3      = !r_s3_valid || en_out;
    assign en_s2      = !r_s2_valid || en_s3;
    assign en_s1      = !r_s1_valid || en_s2;
    assign o_in_ready = en_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_s1)  r_s1_valid  <= i_in_valid;
            if (en_s2)  r_s2_valid  <= r_s1_valid;
            if (en_s3)  r_s3_valid  <= r_s2_valid;
            if (en_out) r_out_valid <= r_s3_valid;
        end
    end

    // beacon byte picks: seek strides 16 bits per channel, remote 8
    always_comb begin
        unique case (i_port_cfg.chan)
            2'd0: n_s1_seek = i_raw_word[7:0];
            2'd1: n_s1_seek = i_raw_word[23:16];
            2'd2: n_s1_seek = i_raw_word[39:32];
            default: n_s1_seek = i_raw_word[55:48];
        endcase
        unique case (i_port_cfg.chan)
            2'd0: n_s1_rem = i_raw_word[7:0];
            2'd1: n_s1_rem = i_raw_word[15:8];
            2'd2: n_s1_rem = i_raw_word[23:16];
            default: n_s1_rem = i_raw_word[31:24];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_mode <= i_port_cfg.mode;
            r_s1_w16  <= i_raw_word[15:0];
            r_s1_seek <= n_s1_seek;
            r_s1_rem  <= n_s1_rem;
        end
    end

    // stage 2 terms: distance / 10 and temperature magnitude in tenths
    always_comb begin
        n_s2_prod = {13'd0, r_s1_w16[11:0]} * {12'd0, DIV10_MUL};
        if (r_s1_w16[15])
            n_s2_hmag = {1'b0, r_s1_w16[14:4] ^ 11'h7FF} + 12'd1;
        else
            n_s2_hmag = r_s1_w16[15:4];
        n_s2_temp = 11'({n_s2_hmag[11:4], 3'd0}) + 11'({n_s2_hmag[11:4], 1'b0})
                  + 11'(frac_tenths(n_s2_hmag[3:0]));
    end

    always_ff @(posedge i_clk) begin
        if (en_s2) begin
            r_s2_mode  <= r_s1_mode;
            r_s2_w16   <= r_s1_w16;
            r_s2_seek  <= r_s1_seek;
            r_s2_rem   <= r_s1_rem;
            r_s2_div10 <= n_s2_prod[24:16];
            r_s2_temp  <= n_s2_temp;
            r_s2_neg   <= r_s1_w16[15];
        end
    end

    // stage 3: pick the mode's value
    always_comb begin
        n_s3_fprod = {17'd0, r_s2_temp} * {11'd0, F_MUL};
        n_s3_ctemp = r_s2_neg ? -VALUE_W'(r_s2_temp) : VALUE_W'(r_s2_temp);
        n_s3_nv    = 1'b0;
        n_s3_value = '1;
        unique case (r_s2_mode)
            MODE_TOUCH: begin
                // signed w16 / 256 is 0 for -255..255 and 13 for 3328..3583
                if (r_s2_w16[15:8] == 8'h00 ||
                    (r_s2_w16[15:8] == 8'hFF && r_s2_w16[7:0] != 8'h00))
                    n_s3_value = '0;
                else if (r_s2_w16[15:8] == 8'h0D)
                    n_s3_value = VALUE_W'(1);
                else
                    n_s3_nv = 1'b1;
            end
            MODE_COL_REF, MODE_COL_AMB, MODE_COL_COL,
            MODE_US_MM, MODE_US_IN, MODE_L_US_CM:
                n_s3_value = VALUE_W'(r_s2_w16[11:0]);
            MODE_US_CM:
                n_s3_value = VALUE_W'(r_s2_div10);
            MODE_GY_ANG, MODE_GY_RATE, MODE_GY_TILT: begin
                if (r_s2_w16[15])
                    n_s3_value = VALUE_W'(r_s2_w16[14:0]) - VALUE_W'(16'h7FFF);
                else
                    n_s3_value = VALUE_W'(r_s2_w16);
            end
            MODE_IR_PROX:
                n_s3_value = VALUE_W'(r_s2_w16[7:0]);
            MODE_IR_SEEK: begin
                if (r_s2_seek[7])
                    n_s3_value = VALUE_W'(r_s2_seek[6:0]) - VALUE_W'(8'h7F);
                else
                    n_s3_value = VALUE_W'(r_s2_seek);
            end
            MODE_IR_REM:
                n_s3_value = VALUE_W'(r_s2_rem);
            MODE_L_SEEKER:
                n_s3_value = VALUE_W'(r_s2_w16[3:0]);
            MODE_L_TEMP_C, MODE_L_TEMP_F:
                n_s3_value = n_s3_ctemp;
            MODE_DIR_DC, MODE_DIR_AC, MODE_DIR_DALL, MODE_DIR_AALL:
                n_s3_value = {r_s2_w16[15], r_s2_w16};
            MODE_COMPASS:
                n_s3_value = {r_s2_w16, 1'b0};
            default:
                n_s3_nv = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en_s3) begin
            r_s3_value <= n_s3_nv ? '1 : n_s3_value;
            r_s3_nv    <= n_s3_nv;
            r_s3_is_f  <= (r_s2_mode == MODE_L_TEMP_F);
            r_s3_neg   <= r_s2_neg;
            r_s3_fq    <= n_s3_fprod[27:16];
        end
    end

    // Fahrenheit: sign of the truncated 9t/5, then the 32-degree offset
    always_comb begin
        n_out_fsigned = r_s3_neg ? -VALUE_W'(r_s3_fq) : VALUE_W'(r_s3_fq);
        n_out_value   = r_s3_is_f ? n_out_fsigned + F_OFFSET : r_s3_value;
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_value <= n_out_value;
            r_out_nv    <= r_s3_nv;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_no_value  = r_out_nv;

endmodule

`default_nettype wire

### rtl/srvd_chk.sv
// Port-level checker for the sensor raw value decoder, bound to the top level.
`default_nettype none

module srvd_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_in_ready,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire logic signed [srvd_pkg::VALUE_W-1:0] o_value,
    input wire logic                            o_no_value
);
    import srvd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value)
            && $stable(o_no_value))
        else $error("stalled result changed");

    a_nv_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_value |-> o_value == '1)
        else $error("no-value result without -1");

    // input back-pressure only comes from a stalled output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input blocked while output free");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result present right after reset");

endmodule

bind sensor_raw_value_decoder srvd_chk u_srvd_chk (.*);

`default_nettype wire
